// ----- hdl/srle_pkg.sv -----
// Shared types and constants for the scanline zero-run RLE decoder.
package srle_pkg;

  localparam int unsigned CountW = 16;

  localparam logic [CountW-1:0] LenOverhead = 16'd2;
  localparam logic [CountW-1:0] CountMax    = 16'hFFFF;

  localparam logic [1:0] CfgLineWidth      = 2'd0;
  localparam logic [1:0] CfgLineTotal      = 2'd1;
  localparam logic [1:0] CfgCompressedMode = 2'd2;

  typedef enum logic [1:0] {
    PH_LEN_LO = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_CODE   = 2'd2,
    PH_RUN    = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [7:0]        length_low;
    logic [CountW-1:0] bytes_left;
    logic [CountW-1:0] column;
    logic [CountW-1:0] lines_done;
  } state_t;

  localparam state_t StateClear = '{
    phase:      PH_LEN_LO,
    length_low: 8'd0,
    bytes_left: '0,
    column:     '0,
    lines_done: '0
  };

  typedef struct packed {
    logic [CountW-1:0] line_width;
    logic [CountW-1:0] line_total;
    logic              compressed_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] pixel_index;
    logic [7:0] run_count;
    logic       line_end;
    logic       image_end;
  } result_t;

endpackage

// ----- hdl/srle_step.sv -----
// Next-state and result logic for one byte of the decoder.
module srle_step (
  input  srle_pkg::state_t  state_i,
  input  srle_pkg::cfg_t    cfg_i,
  input  logic [7:0]        data_byte_i,
  input  logic              image_start_i,
  output srle_pkg::state_t  state_o,
  output srle_pkg::result_t result_o,
  output logic              result_valid_o
);
  import srle_pkg::*;

  state_t            cur;
  logic [CountW-1:0] bl_dec;
  logic [CountW-1:0] col_inc;
  logic [CountW-1:0] ld_inc;
  logic [CountW-1:0] len;
  logic [CountW-1:0] room;
  logic [7:0]        cnt;
  logic              do_close;

  assign cur     = image_start_i ? StateClear : state_i;
  assign bl_dec  = (cur.bytes_left != '0) ? cur.bytes_left - 16'd1 : '0;
  assign col_inc = (cur.column != CountMax) ? cur.column + 16'd1 : cur.column;
  assign ld_inc  = (cur.lines_done != CountMax) ? cur.lines_done + 16'd1 : cur.lines_done;
  assign len     = {data_byte_i, cur.length_low};
  assign room    = (cur.column < cfg_i.line_width) ? cfg_i.line_width - cur.column : '0;
  assign cnt     = (room < {8'd0, data_byte_i}) ? room[7:0] : data_byte_i;

  always_comb begin
    state_o        = cur;
    result_o       = '0;
    result_valid_o = 1'b0;
    do_close       = 1'b0;
    if (cur.lines_done < cfg_i.line_total) begin
      if (!cfg_i.compressed_mode) begin
        result_o.pixel_index = data_byte_i;
        result_o.run_count   = 8'd1;
        result_valid_o       = 1'b1;
        state_o.column       = col_inc;
        do_close             = (col_inc >= cfg_i.line_width);
      end else begin
        case (cur.phase)
          PH_LEN_LO: begin
            state_o.length_low = data_byte_i;
            state_o.phase      = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            state_o.column = '0;
            if (len <= LenOverhead) begin
              result_valid_o = 1'b1;
              do_close       = 1'b1;
            end else begin
              state_o.bytes_left = len - LenOverhead;
              state_o.phase      = PH_CODE;
            end
          end
          PH_CODE: begin
            state_o.bytes_left = bl_dec;
            if (data_byte_i != 8'd0) begin
              result_o.pixel_index = data_byte_i;
              result_o.run_count   = 8'd1;
              result_valid_o       = 1'b1;
              state_o.column       = col_inc;
              do_close             = (bl_dec == '0);
            end else begin
              state_o.phase = PH_RUN;
            end
          end
          PH_RUN: begin
            state_o.bytes_left = bl_dec;
            state_o.column     = cur.column + {8'd0, cnt};
            state_o.phase      = PH_CODE;
            result_o.run_count = cnt;
            do_close           = (bl_dec == '0);
            result_valid_o     = (bl_dec == '0) || (cnt != 8'd0);
          end
          default: begin
            state_o.phase = PH_LEN_LO;
          end
        endcase
      end
    end
    if (do_close) begin
      state_o.column     = '0;
      state_o.phase      = PH_LEN_LO;
      state_o.bytes_left = '0;
      state_o.lines_done = ld_inc;
      result_o.line_end  = 1'b1;
      result_o.image_end = (ld_inc >= cfg_i.line_total);
    end
  end

endmodule

// ----- hdl/shp_ts_scanline_rle_decoder.sv -----
// Top level of the scanline zero-run RLE decoder: registers, handshake, result register.
//
// Takes one image data byte per transaction and gives zero or one result per byte.
// A byte is taken in every cycle while the result register is empty or being
// drained; its result appears on the output in the cycle after acceptance. The
// single result register sets the rate: one byte per cycle sustained, with the
// input stalled only while a result is held under output stall.
module shp_ts_scanline_rle_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        image_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pixel_index_o,
  output logic [7:0]  run_count_o,
  output logic        line_end_o,
  output logic        image_end_o
);
  import srle_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    res_valid;
  logic    out_valid_q, out_valid_d;
  logic    in_accept;

  srle_step u_step (
    .state_i        (state_q),
    .cfg_i          (cfg_q),
    .data_byte_i    (data_byte_i),
    .image_start_i  (image_start_i),
    .state_o        (state_d),
    .result_o       (res_d),
    .result_valid_o (res_valid)
  );

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      state_q     <= StateClear;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgLineWidth:      cfg_q.line_width      <= cfg_data_i;
          CfgLineTotal:      cfg_q.line_total      <= cfg_data_i;
          CfgCompressedMode: cfg_q.compressed_mode <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = res_q.pixel_index;
  assign run_count_o   = res_q.run_count;
  assign line_end_o    = res_q.line_end;
  assign image_end_o   = res_q.image_end;

endmodule
